### rtl/core/unfp_pkg.sv
// Package for the binary GNSS frame parser: widths, frame positions,
// result status codes, register map and controller/datapath bundles.
// No dependencies.
package unfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

  localparam logic [POS_W-1:0] POS_HUNT    = 7'd0;
  localparam logic [POS_W-1:0] POS_SYNC2   = 7'd1;
  localparam logic [POS_W-1:0] POS_CLASS   = 7'd2;
  localparam logic [POS_W-1:0] POS_ID      = 7'd3;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 7'd4;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 7'd5;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 7'd6;

  localparam logic [STATUS_W-1:0] STATUS_PAYLOAD = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MESSAGE_CLASS   = 1'b0;
  localparam logic [BYTE_W-1:0]    MESSAGE_CLASS_RESET = 8'h01;

  typedef struct packed {
    logic take;
    logic clr_idx;
    logic rd;
    logic load_byte;
    logic load_final;
  } dp_cmd_t;

  typedef struct packed {
    logic at_check_b;
    logic sum_ok;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/unfp_in_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on unfp_pkg.
interface unfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [unfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/unfp_out_if.sv
// Result channel: valid/ready handshake carrying one parser result.
// Depends on unfp_pkg.
interface unfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [unfp_pkg::STATUS_W-1:0] status;
  logic [unfp_pkg::BYTE_W-1:0]   message_id;
  logic [unfp_pkg::LEN_W-1:0]    frame_length;
  logic [unfp_pkg::IDX_W-1:0]    byte_index;
  logic [unfp_pkg::BYTE_W-1:0]   payload_byte;
  logic                          last;

  modport source (output valid, output status, output message_id, output frame_length,
                  output byte_index, output payload_byte, output last, input ready);
  modport sink   (input valid, input status, input message_id, input frame_length,
                  input byte_index, input payload_byte, input last, output ready);
endinterface

### rtl/core/unfp_datapath.sv
// Parser datapath: frame position, header fields, Fletcher sums, payload
// buffer memory, emit counter and result output register.
// Depends on unfp_pkg and unfp_out_if.
module unfp_datapath #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  unfp_pkg::dp_cmd_t           cmd,
  output unfp_pkg::dp_status_t        stat,
  input  logic [unfp_pkg::BYTE_W-1:0] rx_byte,
  input  logic [unfp_pkg::BYTE_W-1:0] message_class,
  unfp_out_if.source                  result
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [unfp_pkg::BYTE_W-1:0] MAX_LEN = unfp_pkg::BYTE_W'(MAX_PAYLOAD);

  logic [unfp_pkg::POS_W-1:0]    pos;
  logic [unfp_pkg::BYTE_W-1:0]   held_id;
  logic [unfp_pkg::LEN_W-1:0]    held_length;
  logic [unfp_pkg::BYTE_W-1:0]   sum_a;
  logic [unfp_pkg::BYTE_W-1:0]   sum_b;
  logic [unfp_pkg::BYTE_W-1:0]   rx_sum_a;
  logic [unfp_pkg::BYTE_W-1:0]   mem [MAX_PAYLOAD];
  logic [unfp_pkg::BYTE_W-1:0]   rd_data;
  logic [unfp_pkg::IDX_W-1:0]    idx;

  logic                          out_valid;
  logic [unfp_pkg::STATUS_W-1:0] out_status;
  logic [unfp_pkg::BYTE_W-1:0]   out_id;
  logic [unfp_pkg::LEN_W-1:0]    out_length;
  logic [unfp_pkg::IDX_W-1:0]    out_index;
  logic [unfp_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_last;

  logic [unfp_pkg::POS_W-1:0]    payload_end;
  logic [unfp_pkg::POS_W-1:0]    pos_ofs;
  logic [AW-1:0]                 wr_addr;
  logic [unfp_pkg::BYTE_W-1:0]   sum_a_add;
  logic [unfp_pkg::BYTE_W-1:0]   sum_b_add;
  logic                          in_payload;

  assign payload_end = unfp_pkg::POS_PAYLOAD + held_length;
  assign pos_ofs     = pos - unfp_pkg::POS_PAYLOAD;
  assign wr_addr     = pos_ofs[AW-1:0];
  assign sum_a_add   = sum_a + rx_byte;
  assign sum_b_add   = sum_b + sum_a_add;
  assign in_payload  = (pos >= unfp_pkg::POS_PAYLOAD) && (pos < payload_end);

  assign stat.at_check_b = pos > payload_end;
  assign stat.sum_ok     = (rx_sum_a == sum_a) && (rx_byte == sum_b);
  assign stat.len_zero   = held_length == '0;
  assign stat.idx_last   = ({1'b0, idx} + unfp_pkg::LEN_W'(1)) == held_length;
  assign stat.out_free   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= unfp_pkg::POS_HUNT;
      held_id     <= '0;
      held_length <= '0;
      sum_a       <= '0;
      sum_b       <= '0;
      rx_sum_a    <= '0;
    end else if (cmd.take) begin
      if (pos == unfp_pkg::POS_HUNT) begin
        pos <= (rx_byte == unfp_pkg::SYNC_FIRST) ? unfp_pkg::POS_SYNC2 : unfp_pkg::POS_HUNT;
      end else if (pos == unfp_pkg::POS_SYNC2) begin
        pos <= (rx_byte == unfp_pkg::SYNC_SECOND) ? unfp_pkg::POS_CLASS : unfp_pkg::POS_HUNT;
      end else if (pos == unfp_pkg::POS_CLASS) begin
        if (rx_byte == message_class) begin
          sum_a <= rx_byte;
          sum_b <= rx_byte;
          pos   <= unfp_pkg::POS_ID;
        end else begin
          pos <= unfp_pkg::POS_HUNT;
        end
      end else if (pos == unfp_pkg::POS_ID) begin
        held_id <= rx_byte;
        sum_a   <= sum_a_add;
        sum_b   <= sum_b_add;
        pos     <= unfp_pkg::POS_LEN_LO;
      end else if (pos == unfp_pkg::POS_LEN_LO) begin
        if (rx_byte > MAX_LEN) begin
          pos <= unfp_pkg::POS_HUNT;
        end else begin
          held_length <= rx_byte[unfp_pkg::LEN_W-1:0];
          sum_a       <= sum_a_add;
          sum_b       <= sum_b_add;
          pos         <= unfp_pkg::POS_LEN_HI;
        end
      end else if (pos == unfp_pkg::POS_LEN_HI) begin
        sum_a <= sum_a_add;
        sum_b <= sum_b_add;
        pos   <= unfp_pkg::POS_PAYLOAD;
      end else if (in_payload) begin
        sum_a <= sum_a_add;
        sum_b <= sum_b_add;
        pos   <= pos + unfp_pkg::POS_W'(1);
      end else if (pos == payload_end) begin
        rx_sum_a <= rx_byte;
        pos      <= pos + unfp_pkg::POS_W'(1);
      end else begin
        pos <= unfp_pkg::POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_payload) begin
      mem[wr_addr] <= rx_byte;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.load_byte) begin
      idx <= idx + unfp_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_final) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_status <= unfp_pkg::STATUS_PAYLOAD;
      out_id     <= held_id;
      out_length <= held_length;
      out_index  <= idx;
      out_byte   <= rd_data;
      out_last   <= stat.idx_last;
    end else if (cmd.load_final) begin
      out_status <= stat.sum_ok ? unfp_pkg::STATUS_EMPTY : unfp_pkg::STATUS_ERROR;
      out_id     <= held_id;
      out_length <= held_length;
      out_index  <= '0;
      out_byte   <= '0;
      out_last   <= 1'b1;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.message_id   = out_id;
  assign result.frame_length = out_length;
  assign result.byte_index   = out_index;
  assign result.payload_byte = out_byte;
  assign result.last         = out_last;

endmodule

### rtl/core/unfp_ctrl.sv
// Parser controller: byte intake, frame end decision and payload emit
// sequencing (read buffer, then load result register).
// Depends on unfp_pkg.
module unfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  unfp_pkg::dp_status_t stat,
  output unfp_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_RECV: begin
        in_ready = stat.out_free;
        cmd.take = in_valid && stat.out_free;
        if (cmd.take && stat.at_check_b) begin
          if (stat.sum_ok && !stat.len_zero) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_READ;
          end else begin
            cmd.load_final = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          state_next    = stat.idx_last ? S_RECV : S_READ;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/ubx_nav_frame_parser_top.sv
// Binary GNSS frame parser top level: APB class register, controller and datapath.
// Depends on unfp_pkg, unfp_in_if, unfp_out_if, unfp_ctrl, unfp_datapath.
// Throughput: one byte per cycle while receiving and the result register is free; a good frame
// then emits its payload byte by byte, a registered read of the payload buffer followed by a
// load into the result register. An error or empty-frame result is valid in the cycle after the
// last checksum byte; the first payload result after the read and load. Input stalls during emission.
// Reset (rst, synchronous): parser hunts for sync, no result pending, class = 1;
// the payload buffer is not cleared.
module ubx_nav_frame_parser_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [unfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [unfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [unfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  unfp_in_if.sink                         rx,
  unfp_out_if.source                      result
);

  logic [unfp_pkg::BYTE_W-1:0]    message_class;
  logic [unfp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           in_ready;
  unfp_pkg::dp_cmd_t              cmd;
  unfp_pkg::dp_status_t           stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[unfp_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      message_class <= unfp_pkg::MESSAGE_CLASS_RESET;
    end else if (psel && penable && pwrite && pready
                 && reg_idx == unfp_pkg::REG_MESSAGE_CLASS) begin
      message_class <= pwdata[unfp_pkg::BYTE_W-1:0];
    end
  end

  assign prdata = (reg_idx == unfp_pkg::REG_MESSAGE_CLASS)
                ? unfp_pkg::APB_DATA_W'(message_class) : '0;

  assign rx.ready = in_ready;

  unfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  unfp_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .rx_byte       (rx.rx_byte),
    .message_class (message_class),
    .result        (result)
  );

endmodule

### rtl/core/unfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
// Depends on unfp_pkg and ubx_nav_frame_parser_top.
module unfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [unfp_pkg::STATUS_W-1:0] status,
  input logic [unfp_pkg::LEN_W-1:0]    frame_length,
  input logic [unfp_pkg::IDX_W-1:0]    byte_index,
  input logic [unfp_pkg::BYTE_W-1:0]   payload_byte,
  input logic                          last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte)
      && $stable(byte_index) && $stable(last))
    else $error("result changed while stalled");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != unfp_pkg::STATUS_PAYLOAD
      |-> last && payload_byte == '0 && byte_index == '0)
    else $error("status result not final or carries payload");

  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == unfp_pkg::STATUS_PAYLOAD
      |-> ({1'b0, byte_index} < frame_length)
        && (last == (({1'b0, byte_index} + unfp_pkg::LEN_W'(1)) == frame_length)))
    else $error("payload index inconsistent with length");

  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte taken while result stalled");

endmodule

bind ubx_nav_frame_parser_top unfp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (rx.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .status       (result.status),
  .frame_length (result.frame_length),
  .byte_index   (result.byte_index),
  .payload_byte (result.payload_byte),
  .last         (result.last)
);
